/* hdl/rwt_pkg.sv */
// Shared types and codes for the retransmit window table.
`default_nettype none
package rwt_pkg;

    // Widths that cover a table of up to 256 entries.
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;

    localparam logic [2:0] ACT_BEGIN = 3'd0;
    localparam logic [2:0] ACT_ADD   = 3'd1;
    localparam logic [2:0] ACT_ACK   = 3'd2;
    localparam logic [2:0] ACT_PURGE = 3'd3;
    localparam logic [2:0] ACT_FIND  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_RESOURCE = 3'd2;
    localparam logic [2:0] ST_EXISTS   = 3'd3;
    localparam logic [2:0] ST_STALE    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    localparam logic [1:0] DISP_ACCEPT = 2'd0;
    localparam logic [1:0] DISP_NACK   = 2'd1;

    localparam logic [1:0] CFG_ENTRY_LIMIT = 2'd0;
    localparam logic [1:0] CFG_BYTE_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_AGE_LIMIT   = 2'd2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_TRIM   = 2'd1,
        OP_PURGE  = 2'd2
    } op_t;

    // Token that walks the chain, one cell per cycle.
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [31:0]       src;
        logic [63:0]       seq;
        logic [63:0]       top;
        logic              has_hi;
        logic              accept;
        logic [63:0]       now;
        logic              hit;
        logic [15:0]       hit_len;
        logic [63:0]       hit_time;
        logic [CNT_W-1:0]  rcount;
        logic [31:0]       rbytes;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } tok_t;

    // Broadcast write into one cell.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [31:0]      src;
        logic [63:0]      seq;
        logic [15:0]      len;
        logic [63:0]      tstamp;
    } wr_t;

endpackage
`default_nettype wire

/* hdl/rwt_cell.sv */
// One table slot: holds an entry and updates the passing token.
`default_nettype none
module rwt_cell #(
    parameter int IDX = 0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rwt_pkg::tok_t tok_i,
    output rwt_pkg::tok_t      tok_o,
    input  wire rwt_pkg::wr_t  wr_i,
    input  wire logic [39:0]   age_limit_i
);

    logic        valid_reg;
    logic [31:0] src_reg;
    logic [63:0] seq_reg;
    logic [15:0] len_reg;
    logic [63:0] time_reg;
    rwt_pkg::tok_t tok_reg, tok_next;
    logic drop;
    logic key_match;
    logic [63:0] age;

    assign key_match = valid_reg && (src_reg == tok_i.src) && (seq_reg == tok_i.seq);
    assign age = tok_i.now - time_reg;

    always_comb begin
        tok_next = tok_i;
        drop = 1'b0;
        if (tok_i.valid) begin
            unique case (tok_i.op)
                rwt_pkg::OP_LOOKUP: begin
                    if (key_match && !tok_i.hit) begin
                        tok_next.hit = 1'b1;
                        tok_next.hit_len = len_reg;
                        tok_next.hit_time = time_reg;
                    end
                    if (!valid_reg && !tok_i.free_found) begin
                        tok_next.free_found = 1'b1;
                        tok_next.free_idx = rwt_pkg::IDX_W'(IDX);
                    end
                end
                rwt_pkg::OP_TRIM: begin
                    drop = valid_reg && (src_reg == tok_i.src) &&
                           ((tok_i.has_hi && seq_reg <= tok_i.top) ||
                            (tok_i.accept && seq_reg == tok_i.seq && tok_i.seq > tok_i.top));
                end
                rwt_pkg::OP_PURGE: begin
                    drop = valid_reg && (tok_i.now >= time_reg) &&
                           (age > {24'd0, age_limit_i});
                end
                default: drop = 1'b0;
            endcase
            if (drop) begin
                tok_next.rcount = tok_i.rcount + 1'b1;
                tok_next.rbytes = tok_i.rbytes + {16'd0, len_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_i.en && wr_i.idx == rwt_pkg::IDX_W'(IDX)) begin
            src_reg  <= wr_i.src;
            seq_reg  <= wr_i.seq;
            len_reg  <= wr_i.len;
            time_reg <= wr_i.tstamp;
        end
        if (!aresetn) begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (wr_i.en && wr_i.idx == rwt_pkg::IDX_W'(IDX)) begin
                valid_reg <= 1'b1;
            end else if (drop) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign tok_o = tok_reg;

endmodule
`default_nettype wire

/* hdl/retransmit_window_table.sv */
// Top level of the retransmit window table: control, totals and the slot chain.
`default_nettype none
// The table holds up to ENTRIES unacknowledged frames, one per cell of a chain.
// Begin session, adds rejected at input for session, fields or length, stale or
// malformed acks and unknown actions answer from the controller alone: the result
// register loads at the input beat, so the result beat can leave in the next cycle.
// Add, ack, purge and find send a token down the chain, one cell per cycle; the
// result register loads when the token leaves the last cell. One item is in work
// at a time; the next input beat is taken in the cycle after the result beat has left.
// Configuration writes are always ready. No clearing pass is needed after
// reset: per-slot valid flags clear at once.
module retransmit_window_table #(
    parameter int ENTRIES     = 32,
    parameter int SOURCE_BITS = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // source_id[31:0], sequence_number[95:32], highest_sequence[159:96],
    // has_highest[160], disposition[162:161], local_epoch[226:163],
    // remote_epoch[290:227], frame_length[306:291], now_time[370:307]
    input  wire logic [375:0] s_tdata,
    // action[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // removed_count[5:0], freed_bytes[37:6], found_length[53:38],
    // found_time[117:54], bytes_held[149:118], entries_held[155:150]
    output logic [159:0]      m_tdata,
    // status[2:0]
    output logic [2:0]        m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [39:0]  cfg_data
);

    localparam int CW = rwt_pkg::CNT_W;
    localparam logic [31:0] SRC_MASK =
        (SOURCE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << SOURCE_BITS) - 64'd1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [5:0]  entry_limit_reg;
    logic [31:0] byte_limit_reg;
    logic [39:0] age_limit_reg;

    // session and totals
    logic        session_reg, session_next;
    logic [63:0] lep_reg, lep_next;
    logic [63:0] rep_reg, rep_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // item held during a scan
    logic [2:0]  it_action_reg, it_action_next;
    logic [31:0] it_src_reg, it_src_next;
    logic [63:0] it_seq_reg, it_seq_next;
    logic [15:0] it_len_reg, it_len_next;
    logic [63:0] it_now_reg, it_now_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [5:0]  out_rcount_reg, out_rcount_next;
    logic [31:0] out_rbytes_reg, out_rbytes_next;
    logic [15:0] out_flen_reg, out_flen_next;
    logic [63:0] out_ftime_reg, out_ftime_next;
    logic [31:0] out_bytes_reg, out_bytes_next;
    logic [5:0]  out_entries_reg, out_entries_next;

    rwt_pkg::tok_t tok_head;
    rwt_pkg::tok_t tok_w [ENTRIES];
    rwt_pkg::tok_t tok_end;
    rwt_pkg::wr_t  wr;

    logic        accept;
    logic [31:0] in_src;
    logic [63:0] in_seq, in_hi, in_lep, in_rep, in_now;
    logic        in_hh;
    logic [1:0]  in_disp;
    logic [15:0] in_len;

    assign in_src  = s_tdata[31:0] & SRC_MASK;
    assign in_seq  = s_tdata[95:32];
    assign in_hi   = s_tdata[159:96];
    assign in_hh   = s_tdata[160];
    assign in_disp = s_tdata[162:161];
    assign in_lep  = s_tdata[226:163];
    assign in_rep  = s_tdata[290:227];
    assign in_len  = s_tdata[306:291];
    assign in_now  = s_tdata[370:307];

    assign s_tready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign tok_end   = tok_w[ENTRIES-1];

    always_comb begin
        state_next     = state_reg;
        session_next   = session_reg;
        lep_next       = lep_reg;
        rep_next       = rep_reg;
        bytes_next     = bytes_reg;
        cnt_next       = cnt_reg;
        it_action_next = it_action_reg;
        it_src_next    = it_src_reg;
        it_seq_next    = it_seq_reg;
        it_len_next    = it_len_reg;
        it_now_next    = it_now_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_rcount_next  = out_rcount_reg;
        out_rbytes_next  = out_rbytes_reg;
        out_flen_next    = out_flen_reg;
        out_ftime_next   = out_ftime_reg;
        out_bytes_next   = out_bytes_reg;
        out_entries_next = out_entries_reg;
        tok_head = '0;
        wr = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (accept) begin
            it_action_next = s_tuser;
            it_src_next    = in_src;
            it_seq_next    = in_seq;
            it_len_next    = in_len;
            it_now_next    = in_now;
            // default: answer at once with nothing removed or found
            out_valid_next   = 1'b1;
            out_status_next  = rwt_pkg::ST_OK;
            out_rcount_next  = 6'd0;
            out_rbytes_next  = 32'd0;
            out_flen_next    = 16'd0;
            out_ftime_next   = 64'd0;
            out_bytes_next   = bytes_reg;
            out_entries_next = 6'(cnt_reg);
            tok_head.src = in_src;
            tok_head.seq = in_seq;
            tok_head.now = in_now;
            unique case (s_tuser)
                rwt_pkg::ACT_BEGIN: begin
                    session_next = 1'b1;
                    lep_next = in_lep;
                    rep_next = in_rep;
                end
                rwt_pkg::ACT_ADD: begin
                    if (!session_reg || in_seq == 64'd0 || in_len == 16'd0) begin
                        out_status_next = rwt_pkg::ST_INVALID;
                    end else if ({16'd0, in_len} > byte_limit_reg) begin
                        out_status_next = rwt_pkg::ST_RESOURCE;
                    end else begin
                        out_valid_next = 1'b0;
                        state_next = S_SCAN;
                        tok_head.valid = 1'b1;
                        tok_head.op = rwt_pkg::OP_LOOKUP;
                    end
                end
                rwt_pkg::ACT_ACK: begin
                    if (!session_reg || in_lep != lep_reg || in_rep != rep_reg) begin
                        out_status_next = rwt_pkg::ST_STALE;
                    end else if (in_disp != rwt_pkg::DISP_ACCEPT &&
                                 !(in_disp == rwt_pkg::DISP_NACK && in_hh)) begin
                        out_status_next = rwt_pkg::ST_INVALID;
                    end else begin
                        out_valid_next = 1'b0;
                        state_next = S_SCAN;
                        tok_head.valid  = 1'b1;
                        tok_head.op     = rwt_pkg::OP_TRIM;
                        tok_head.has_hi = in_hh;
                        tok_head.top    = in_hh ? in_hi : 64'd0;
                        tok_head.accept = (in_disp == rwt_pkg::DISP_ACCEPT);
                    end
                end
                rwt_pkg::ACT_PURGE: begin
                    out_valid_next = 1'b0;
                    state_next = S_SCAN;
                    tok_head.valid = 1'b1;
                    tok_head.op = rwt_pkg::OP_PURGE;
                end
                rwt_pkg::ACT_FIND: begin
                    out_valid_next = 1'b0;
                    state_next = S_SCAN;
                    tok_head.valid = 1'b1;
                    tok_head.op = rwt_pkg::OP_LOOKUP;
                end
                default: out_status_next = rwt_pkg::ST_INVALID;
            endcase
        end

        // token back from the last cell: settle the item
        if (state_reg == S_SCAN && tok_end.valid) begin
            state_next      = S_IDLE;
            out_valid_next  = 1'b1;
            out_status_next = rwt_pkg::ST_OK;
            out_rcount_next = 6'd0;
            out_rbytes_next = 32'd0;
            out_flen_next   = 16'd0;
            out_ftime_next  = 64'd0;
            unique case (it_action_reg)
                rwt_pkg::ACT_ADD: begin
                    if (tok_end.hit) begin
                        out_status_next = rwt_pkg::ST_EXISTS;
                    end else if (cnt_reg >= {3'd0, entry_limit_reg} ||
                                 cnt_reg >= CW'(ENTRIES)) begin
                        out_status_next = rwt_pkg::ST_RESOURCE;
                    end else if (bytes_reg > byte_limit_reg - {16'd0, it_len_reg}) begin
                        out_status_next = rwt_pkg::ST_RESOURCE;
                    end else begin
                        wr.en     = 1'b1;
                        wr.idx    = tok_end.free_idx;
                        wr.src    = it_src_reg;
                        wr.seq    = it_seq_reg;
                        wr.len    = it_len_reg;
                        wr.tstamp = it_now_reg;
                        bytes_next = bytes_reg + {16'd0, it_len_reg};
                        cnt_next   = cnt_reg + 1'b1;
                    end
                end
                rwt_pkg::ACT_FIND: begin
                    if (tok_end.hit) begin
                        out_flen_next  = tok_end.hit_len;
                        out_ftime_next = tok_end.hit_time;
                    end else begin
                        out_status_next = rwt_pkg::ST_NOTFOUND;
                    end
                end
                rwt_pkg::ACT_ACK: begin
                    out_rcount_next = 6'(tok_end.rcount);
                    out_rbytes_next = tok_end.rbytes;
                    bytes_next = bytes_reg - tok_end.rbytes;
                    cnt_next   = cnt_reg - tok_end.rcount;
                end
                rwt_pkg::ACT_PURGE: begin
                    out_rcount_next = 6'(tok_end.rcount);
                    bytes_next = bytes_reg - tok_end.rbytes;
                    cnt_next   = cnt_reg - tok_end.rcount;
                end
                default: out_status_next = rwt_pkg::ST_INVALID;
            endcase
            out_bytes_next   = bytes_next;
            out_entries_next = 6'(cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            session_reg     <= 1'b0;
            lep_reg         <= 64'd0;
            rep_reg         <= 64'd0;
            bytes_reg       <= 32'd0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            entry_limit_reg <= 6'd32;
            byte_limit_reg  <= 32'd1048576;
            age_limit_reg   <= 40'd1000000000;
        end else begin
            state_reg     <= state_next;
            session_reg   <= session_next;
            lep_reg       <= lep_next;
            rep_reg       <= rep_next;
            bytes_reg     <= bytes_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    rwt_pkg::CFG_ENTRY_LIMIT: entry_limit_reg <= cfg_data[5:0];
                    rwt_pkg::CFG_BYTE_LIMIT:  byte_limit_reg  <= cfg_data[31:0];
                    rwt_pkg::CFG_AGE_LIMIT:   age_limit_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
        it_action_reg   <= it_action_next;
        it_src_reg      <= it_src_next;
        it_seq_reg      <= it_seq_next;
        it_len_reg      <= it_len_next;
        it_now_reg      <= it_now_next;
        out_status_reg  <= out_status_next;
        out_rcount_reg  <= out_rcount_next;
        out_rbytes_reg  <= out_rbytes_next;
        out_flen_reg    <= out_flen_next;
        out_ftime_reg   <= out_ftime_next;
        out_bytes_reg   <= out_bytes_next;
        out_entries_reg <= out_entries_next;
    end

    // slot chain: advance the token one cell per cycle
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        rwt_pkg::tok_t tok_in;
        if (g == 0) begin : g_head
            assign tok_in = tok_head;
        end else begin : g_link
            assign tok_in = tok_w[g-1];
        end
        rwt_cell #(.IDX(g)) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .tok_i       (tok_in),
            .tok_o       (tok_w[g]),
            .wr_i        (wr),
            .age_limit_i (age_limit_reg)
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_entries_reg, out_bytes_reg, out_ftime_reg,
                       out_flen_reg, out_rbytes_reg, out_rcount_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(ENTRIES))
        else $error("entry count above table depth");
    a_token_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_end.valid |-> state_reg == S_SCAN)
        else $error("token returned outside a scan");
    a_accept_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !out_valid_reg && state_reg == S_IDLE)
        else $error("input taken while busy");
    a_scan_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && tok_end.valid) |=> out_valid_reg)
        else $error("scan finished without a result");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the retransmit window table: random actions against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    // One action beat as offered on the slave side.
    typedef struct {
        logic [2:0]  action;
        logic [31:0] source_id;
        logic [63:0] sequence_number;
        logic [63:0] highest_sequence;
        logic        has_highest;
        logic [1:0]  disposition;
        logic [63:0] local_epoch;
        logic [63:0] remote_epoch;
        logic [15:0] frame_length;
        logic [63:0] now_time;
    } action_t;

    // One answer beat as expected on the master side.
    typedef struct {
        logic [2:0]  status;
        logic [5:0]  removed_count;
        logic [31:0] freed_bytes;
        logic [15:0] found_length;
        logic [63:0] found_time;
        logic [31:0] bytes_held;
        logic [5:0]  entries_held;
    } answer_t;

    localparam int DEPTH = 32;
    localparam int SETTLE = 80;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [375:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [39:0] cfg_data = '0;

    always #2 aclk = ~aclk;

    retransmit_window_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor copy of the window.
    logic        win_valid [DEPTH];
    logic [31:0] win_src [DEPTH];
    logic [63:0] win_seq [DEPTH];
    logic [15:0] win_len [DEPTH];
    logic [63:0] win_time [DEPTH];
    logic [31:0] win_bytes;
    logic        win_session;
    logic [63:0] win_lep, win_rep;
    logic [5:0]  lim_entries;
    logic [31:0] lim_bytes;
    logic [39:0] lim_age;

    action_t pending_actions[$];
    answer_t expected_answers[$];
    int errors = 0;
    bit pause_sender = 0;
    bit hold_receiver = 0;

    // Key pools keep adds, acks and finds colliding.
    logic [31:0] src_pool [4];
    logic [63:0] ep_lep, ep_rep;

    function automatic void queue_action(action_t a);
        pending_actions.insert(pending_actions.size(), a);
    endfunction

    function automatic int held_count();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++) if (win_valid[i]) n++;
        return n;
    endfunction

    function automatic int lookup_slot(logic [31:0] src, logic [63:0] seq);
        for (int i = 0; i < DEPTH; i++)
            if (win_valid[i] && win_src[i] == src && win_seq[i] == seq) return i;
        return -1;
    endfunction

    // Apply one action to the predictor and return its answer.
    function automatic answer_t window_step(action_t a);
        answer_t r;
        int held, k;
        logic [63:0] top;
        r = '{default: '0};
        r.status = rwt_pkg::ST_OK;
        case (a.action)
            rwt_pkg::ACT_BEGIN: begin
                if (!(win_session && win_lep == a.local_epoch &&
                      win_rep == a.remote_epoch)) begin
                    win_session = 1'b1;
                    win_lep = a.local_epoch;
                    win_rep = a.remote_epoch;
                end
            end
            rwt_pkg::ACT_ADD: begin
                held = held_count();
                if (!win_session || a.sequence_number == 0 || a.frame_length == 0)
                    r.status = rwt_pkg::ST_INVALID;
                else if (32'(a.frame_length) > lim_bytes)
                    r.status = rwt_pkg::ST_RESOURCE;
                else if (lookup_slot(a.source_id, a.sequence_number) >= 0)
                    r.status = rwt_pkg::ST_EXISTS;
                else if (held >= int'(lim_entries) || held >= DEPTH)
                    r.status = rwt_pkg::ST_RESOURCE;
                else if (win_bytes > lim_bytes - 32'(a.frame_length))
                    r.status = rwt_pkg::ST_RESOURCE;
                else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!win_valid[i]) begin
                            win_valid[i] = 1'b1;
                            win_src[i] = a.source_id;
                            win_seq[i] = a.sequence_number;
                            win_len[i] = a.frame_length;
                            win_time[i] = a.now_time;
                            win_bytes += 32'(a.frame_length);
                            break;
                        end
                    end
                end
            end
            rwt_pkg::ACT_ACK: begin
                if (!win_session || a.local_epoch != win_lep || a.remote_epoch != win_rep)
                    r.status = rwt_pkg::ST_STALE;
                else if (a.disposition > rwt_pkg::DISP_NACK ||
                         (a.disposition == rwt_pkg::DISP_NACK && !a.has_highest))
                    r.status = rwt_pkg::ST_INVALID;
                else begin
                    top = a.has_highest ? a.highest_sequence : 64'd0;
                    if (a.has_highest)
                        for (int i = 0; i < DEPTH; i++)
                            if (win_valid[i] && win_src[i] == a.source_id &&
                                win_seq[i] <= top) begin
                                win_valid[i] = 1'b0;
                                win_bytes -= 32'(win_len[i]);
                                r.removed_count++;
                                r.freed_bytes += 32'(win_len[i]);
                            end
                    if (a.disposition == rwt_pkg::DISP_ACCEPT && a.sequence_number > top) begin
                        k = lookup_slot(a.source_id, a.sequence_number);
                        if (k >= 0) begin
                            win_valid[k] = 1'b0;
                            win_bytes -= 32'(win_len[k]);
                            r.removed_count++;
                            r.freed_bytes += 32'(win_len[k]);
                        end
                    end
                end
            end
            rwt_pkg::ACT_PURGE: begin
                for (int i = 0; i < DEPTH; i++)
                    if (win_valid[i] && a.now_time >= win_time[i] &&
                        a.now_time - win_time[i] > 64'(lim_age)) begin
                        win_valid[i] = 1'b0;
                        win_bytes -= 32'(win_len[i]);
                        r.removed_count++;
                    end
            end
            rwt_pkg::ACT_FIND: begin
                k = lookup_slot(a.source_id, a.sequence_number);
                if (k >= 0) begin
                    r.found_length = win_len[k];
                    r.found_time = win_time[k];
                end else
                    r.status = rwt_pkg::ST_NOTFOUND;
            end
            default: r.status = rwt_pkg::ST_INVALID;
        endcase
        r.bytes_held = win_bytes;
        r.entries_held = 6'(held_count());
        return r;
    endfunction

    // Random item, biased toward keys and epochs the window knows.
    function automatic action_t random_action();
        action_t a;
        int pick;
        pick = $urandom_range(0, 99);
        a.action = pick < 8 ? rwt_pkg::ACT_BEGIN : pick < 50 ? rwt_pkg::ACT_ADD :
                   pick < 72 ? rwt_pkg::ACT_ACK : pick < 80 ? rwt_pkg::ACT_PURGE :
                   pick < 97 ? rwt_pkg::ACT_FIND : 3'($urandom_range(5, 7));
        a.source_id = ($urandom_range(0, 9) == 0) ? $urandom : src_pool[$urandom_range(0, 3)];
        a.sequence_number = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                       : 64'($urandom_range(0, 40));
        a.highest_sequence = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                        : 64'($urandom_range(0, 40));
        a.has_highest = 1'($urandom_range(0, 1));
        a.disposition = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1));
        a.local_epoch = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : ep_lep;
        a.remote_epoch = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : ep_rep;
        a.frame_length = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 3000));
        a.now_time = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                : 64'($urandom_range(0, 2000000));
        // New epochs stick so later acks match them.
        if (a.action == rwt_pkg::ACT_BEGIN) begin
            ep_lep = a.local_epoch;
            ep_rep = a.remote_epoch;
        end
        return a;
    endfunction

    function automatic action_t make_action(logic [2:0] act, logic [31:0] src, logic [63:0] seq,
                                            logic [63:0] hi, logic hh, logic [1:0] disp,
                                            logic [15:0] len, logic [63:0] now);
        action_t a;
        a.action = act; a.source_id = src; a.sequence_number = seq;
        a.highest_sequence = hi; a.has_highest = hh; a.disposition = disp;
        a.local_epoch = ep_lep; a.remote_epoch = ep_rep;
        a.frame_length = len; a.now_time = now;
        return a;
    endfunction

    // Driver: pop queued items, hold the beat until accepted.
    always @(posedge aclk) begin
        action_t a;
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_actions.size() > 0 && !pause_sender &&
                    $urandom_range(0, 3) != 0) begin
                    a = pending_actions.pop_front();
                    expected_answers.insert(expected_answers.size(), window_step(a));
                    s_tvalid <= 1'b1;
                    s_tuser <= a.action;
                    s_tdata <= {5'd0, a.now_time, a.frame_length, a.remote_epoch,
                                a.local_epoch, a.disposition, a.has_highest,
                                a.highest_sequence, a.sequence_number, a.source_id};
                end else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Idle gap lengths: mostly short, a few long.
    int rx_wait = 0;
    always @(posedge aclk) begin
        if (hold_receiver)
            m_tready <= 1'b0;
        else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            rx_wait <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else
            m_tready <= 1'b1;
    end

    // Monitor: compare each answer beat with the oldest prediction.
    always @(posedge aclk) begin
        answer_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_answers.size() == 0) begin
                $error("answer beat with nothing expected");
                errors++;
            end else begin
                e = expected_answers.pop_front();
                if (m_tuser != e.status) begin
                    $error("status exp %0d got %0d", e.status, m_tuser); errors++;
                end
                if (m_tdata[5:0] != e.removed_count) begin
                    $error("removed_count exp %0d got %0d", e.removed_count, m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[37:6] != e.freed_bytes) begin
                    $error("freed_bytes exp %0d got %0d", e.freed_bytes, m_tdata[37:6]);
                    errors++;
                end
                if (m_tdata[53:38] != e.found_length) begin
                    $error("found_length exp %0d got %0d", e.found_length, m_tdata[53:38]);
                    errors++;
                end
                if (m_tdata[117:54] != e.found_time) begin
                    $error("found_time exp %0d got %0d", e.found_time, m_tdata[117:54]);
                    errors++;
                end
                if (m_tdata[149:118] != e.bytes_held) begin
                    $error("bytes_held exp %0d got %0d", e.bytes_held, m_tdata[149:118]);
                    errors++;
                end
                if (m_tdata[155:150] != e.entries_held) begin
                    $error("entries_held exp %0d got %0d", e.entries_held, m_tdata[155:150]);
                    errors++;
                end
            end
        end
    end

    // Drain: wait until the driver queue, the wire and the predictions are empty.
    task automatic drain();
        while (pending_actions.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [39:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            rwt_pkg::CFG_ENTRY_LIMIT: lim_entries = val[5:0];
            rwt_pkg::CFG_BYTE_LIMIT:  lim_bytes = val[31:0];
            default:                  lim_age = val;
        endcase
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) win_valid[i] = 1'b0;
        win_bytes = 0; win_session = 0; win_lep = 0; win_rep = 0;
        lim_entries = 6'd32; lim_bytes = 32'd1048576; lim_age = 40'd1000000000;
        for (int i = 0; i < 4; i++) src_pool[i] = (i == 3) ? 32'hFFFFFFFF : 32'(i);
        ep_lep = 64'd0; ep_rep = 64'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: no-session paths, then session, extremes and every action.
        queue_action(make_action(rwt_pkg::ACT_ADD, 1, 5, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd10, 0));
        queue_action(make_action(rwt_pkg::ACT_ACK, 1, 5, 9, 1'b1, rwt_pkg::DISP_ACCEPT,
                                 16'd0, 0));
        ep_lep = 64'hFFFFFFFFFFFFFFFF; ep_rep = 64'd0;
        queue_action(make_action(rwt_pkg::ACT_BEGIN, 0, 0, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd0, 0));
        queue_action(make_action(rwt_pkg::ACT_BEGIN, 0, 0, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd0, 0));
        queue_action(make_action(rwt_pkg::ACT_ADD, 1, 0, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd10, 0));
        queue_action(make_action(rwt_pkg::ACT_ADD, 1, 3, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd0, 0));
        queue_action(make_action(rwt_pkg::ACT_ADD, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 0, 1'b0,
                                 rwt_pkg::DISP_ACCEPT, 16'hFFFF, 64'hFFFFFFFFFFFFFFFF));
        queue_action(make_action(rwt_pkg::ACT_ADD, 1, 3, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd100, 5));
        queue_action(make_action(rwt_pkg::ACT_ADD, 1, 3, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd100, 5));
        queue_action(make_action(rwt_pkg::ACT_ADD, 1, 4, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd200, 6));
        queue_action(make_action(rwt_pkg::ACT_ADD, 1, 9, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd300, 7));
        queue_action(make_action(rwt_pkg::ACT_FIND, 1, 4, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd0, 0));
        queue_action(make_action(rwt_pkg::ACT_FIND, 2, 4, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd0, 0));
        queue_action(make_action(rwt_pkg::ACT_ACK, 1, 9, 3, 1'b1, rwt_pkg::DISP_ACCEPT,
                                 16'd0, 0));
        queue_action(make_action(rwt_pkg::ACT_ACK, 1, 4, 4, 1'b0, rwt_pkg::DISP_NACK,
                                 16'd0, 0));
        queue_action(make_action(rwt_pkg::ACT_ACK, 1, 4, 4, 1'b1, 2'd3, 16'd0, 0));
        queue_action(make_action(rwt_pkg::ACT_ACK, 1, 4, 4, 1'b1, rwt_pkg::DISP_NACK,
                                 16'd0, 0));
        queue_action(make_action(rwt_pkg::ACT_PURGE, 0, 0, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd0, 1));
        queue_action(make_action(rwt_pkg::ACT_PURGE, 0, 0, 0, 1'b0, rwt_pkg::DISP_ACCEPT,
                                 16'd0, 64'd2000000000));
        queue_action(make_action(3'd7, 0, 0, 0, 1'b0, rwt_pkg::DISP_ACCEPT, 16'd0, 0));
        queue_action(make_action(3'd5, 0, 0, 0, 1'b0, rwt_pkg::DISP_ACCEPT, 16'd0, 0));
        drain();

        // Phases across register settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(rwt_pkg::CFG_ENTRY_LIMIT, 40'd1);
                         write_reg(rwt_pkg::CFG_BYTE_LIMIT, 40'd1);
                         write_reg(rwt_pkg::CFG_AGE_LIMIT, 40'd1); end
                1: begin write_reg(rwt_pkg::CFG_ENTRY_LIMIT, 40'd4);
                         write_reg(rwt_pkg::CFG_BYTE_LIMIT, 40'd5000);
                         write_reg(rwt_pkg::CFG_AGE_LIMIT, 40'd300000); end
                2: begin write_reg(rwt_pkg::CFG_ENTRY_LIMIT, 40'd32);
                         write_reg(rwt_pkg::CFG_BYTE_LIMIT, 40'hFFFFFFFF);
                         write_reg(rwt_pkg::CFG_AGE_LIMIT, 40'hFFFFFFFFFF); end
                3: begin write_reg(rwt_pkg::CFG_ENTRY_LIMIT, 40'd63);
                         write_reg(rwt_pkg::CFG_BYTE_LIMIT, 40'd40000);
                         write_reg(rwt_pkg::CFG_AGE_LIMIT, 40'd500000); end
                4: begin write_reg(rwt_pkg::CFG_ENTRY_LIMIT, 40'd0); end
                default: begin write_reg(rwt_pkg::CFG_ENTRY_LIMIT, 40'd20);
                         write_reg(rwt_pkg::CFG_BYTE_LIMIT, 40'd1048576);
                         write_reg(rwt_pkg::CFG_AGE_LIMIT, 40'd1000000); end
            endcase
            for (int n = 0; n < 300; n++) queue_action(random_action());
            if (ph == 2) begin
                // Long receiver hold while the sender keeps offering.
                repeat (20) @(posedge aclk);
                hold_receiver = 1;
                repeat (400) @(posedge aclk);
                hold_receiver = 0;
            end
            if (ph == 3) begin
                // Sender pause until every pending answer is in.
                repeat (100) @(posedge aclk);
                pause_sender = 1;
                while (s_tvalid || expected_answers.size() > 0) @(posedge aclk);
                pause_sender = 0;
            end
            drain();
        end

        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #4000000;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
